/* design/dgpe_pkg.sv */
// Shared types, constants and helpers for the dual-gradient pixel energy block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dgpe_pkg;

    // Energy given to every pixel on the image border
    localparam logic [18:0] BORDER_ENERGY = 19'd195075;

    // Configuration register map and widths
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;
    localparam int   CFG_WIDTH_W      = 11;
    localparam int   CFG_HEIGHT_W     = 13;
    localparam int   CFG_DATA_W       = 13;
    localparam int   CFG_WIDTH_RESET  = 1024;
    localparam int   CFG_HEIGHT_RESET = 768;

    // One pixel, red in the upper byte
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // Per-pixel control carried alongside the arithmetic
    typedef struct packed {
        logic [11:0] row_above;  // row of the pixel above (r-1)
        logic [11:0] row_cur;    // row of the incoming pixel (r)
        logic [9:0]  col;        // column of both
        logic        has_above;  // a result for row r-1 is due
        logic        last_row;   // a border result for row r is due
        logic        border;     // the row r-1 pixel sits on the border
    } item_meta_t;

    // Square of the difference of two channel values
    function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] mag;
        mag = (a >= b) ? (a - b) : (b - a);
        return 16'(mag) * 16'(mag);
    endfunction

endpackage

`default_nettype wire

/* design/dual_gradient_pixel_energy.sv */
// Top level of the dual-gradient pixel energy block: position counters, configuration,
// line-buffer read stage and write-back. Depends on dgpe_pkg, dgpe_line_buf, dgpe_grad, dgpe_out.
`default_nettype none

// Pixels enter in raster order at one per clock while s_tready is high. A request at (r,c)
// reads column c and c+1 of the previous row and column c of the row before it from the
// line-buffer RAMs and writes both rows back as it leaves the read stage, so a full line
// rate is kept. The result for (r-1,c) passes the read stage, both gradient stages and
// the output register; on the last row a request makes two results (above, then its own
// border value) and the single-result output port takes no new pixel until both have left.
// Row 0 only ever gives border values, so the line buffers need no clearing after reset.
// A configuration write restarts the frame and should be made while no request is in flight.
module dual_gradient_pixel_energy
    import dgpe_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Pixel stream in
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [23:0]           s_tdata,   // red[7:0], green[15:8], blue[23:16]
    // Energy stream out
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [47:0]                m_tdata,   // energy[18:0], row_index[30:19],
                                                  // col_index[40:31], zeros[47:41]
    output logic                       m_tlast,   // last_in_run
    // Configuration
    input  wire logic                  wr_en,
    input  wire logic                  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WXW = (CW + 1 > CFG_WIDTH_W) ? CW + 1 : CFG_WIDTH_W;
    localparam int HXW = (RW + 1 > CFG_HEIGHT_W) ? RW + 1 : CFG_HEIGHT_W;
    localparam int RXW = (RW > 12) ? RW : 12;
    localparam int CXW = (CW > 10) ? CW : 10;
    localparam int RST_W = (CFG_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_WIDTH_RESET;
    localparam int RST_H = (CFG_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : CFG_HEIGHT_RESET;

    // Configuration, kept as last column / last row
    logic [CW-1:0]  w_last_reg;
    logic [RW-1:0]  h_last_reg;
    logic [WXW-1:0] wr_w;
    logic [WXW-1:0] eff_w;
    logic [HXW-1:0] wr_h;
    logic [HXW-1:0] eff_h;

    // Position of the next pixel
    logic [CW-1:0]  col_count_reg;
    logic [CW-1:0]  col_count_next;
    logic [RW-1:0]  row_count_reg;
    logic [RW-1:0]  row_count_next;

    // Read stage
    logic           v1_reg;
    item_meta_t     meta1_reg;
    item_meta_t     meta_in;
    pixel_t         cur1_reg;
    logic [CW-1:0]  col1_reg;
    pixel_t         left_above_reg;
    pixel_t         pix_in;
    logic [RXW-1:0] row_ext;
    logic [RXW-1:0] row_m1_ext;
    logic [CXW-1:0] col_ext;
    logic           accept;
    logic           adv1;

    pixel_t         above;
    pixel_t         right;
    pixel_t         older;

    logic           g_in_ready;
    logic           g_out_valid;
    logic           o_in_ready;
    item_meta_t     g_meta;
    logic [18:0]    g_energy;
    logic [18:0]    energy;
    logic [11:0]    row_index;
    logic [9:0]     col_index;

    assign s_tready = !v1_reg || g_in_ready;
    assign accept   = s_tvalid && s_tready;
    assign adv1     = v1_reg && g_in_ready;

    assign pix_in.red   = s_tdata[7:0];
    assign pix_in.green = s_tdata[15:8];
    assign pix_in.blue  = s_tdata[23:16];

    // Zero means one, oversize saturates
    always_comb
    begin
        wr_w = WXW'(wr_data[CFG_WIDTH_W-1:0]);
        if (wr_w == '0)
            eff_w = WXW'(1);
        else if (wr_w > WXW'(MAX_WIDTH))
            eff_w = WXW'(MAX_WIDTH);
        else
            eff_w = wr_w;

        wr_h = HXW'(wr_data[CFG_HEIGHT_W-1:0]);
        if (wr_h == '0)
            eff_h = HXW'(1);
        else if (wr_h > HXW'(MAX_HEIGHT))
            eff_h = HXW'(MAX_HEIGHT);
        else
            eff_h = wr_h;
    end

    // Raster position advance
    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept)
        begin
            if (col_count_reg == w_last_reg)
            begin
                col_count_next = '0;
                if (row_count_reg == h_last_reg)
                    row_count_next = '0;
                else
                    row_count_next = row_count_reg + 1'b1;
            end
            else
            begin
                col_count_next = col_count_reg + 1'b1;
            end
        end
    end

    // Control for this pixel
    always_comb
    begin
        row_ext    = RXW'(row_count_reg);
        row_m1_ext = RXW'(row_count_reg - 1'b1);
        col_ext    = CXW'(col_count_reg);

        meta_in.row_above = row_m1_ext[11:0];
        meta_in.row_cur   = row_ext[11:0];
        meta_in.col       = col_ext[9:0];
        meta_in.has_above = (row_count_reg != '0);
        meta_in.last_row  = (row_count_reg == h_last_reg);
        meta_in.border    = (row_count_reg == RW'(1)) || (col_count_reg == '0)
                         || (col_count_reg == w_last_reg);
    end

    // Config and counters; a config write restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg    <= CW'(RST_W - 1);
            h_last_reg    <= RW'(RST_H - 1);
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_IMAGE_WIDTH:  w_last_reg <= CW'(eff_w - WXW'(1));
                REG_IMAGE_HEIGHT: h_last_reg <= RW'(eff_h - HXW'(1));
                default:          w_last_reg <= w_last_reg;
            endcase
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // Read stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (accept)
            v1_reg <= 1'b1;
        else if (adv1)
            v1_reg <= 1'b0;
    end

    // Read stage payload and left-above pixel
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            meta1_reg <= meta_in;
            cur1_reg  <= pix_in;
            col1_reg  <= col_count_reg;
        end
        if (adv1)
            left_above_reg <= above;
    end

    // Same-edge read/write of one column only happens at widths 1 and 2,
    // where every result is a border value
    dgpe_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .clk          (clk),
        .rd_en        (accept),
        .rd_addr      (col_count_reg),
        .rd_addr_next (col_count_reg + 1'b1),
        .wr_en        (adv1),
        .wr_addr      (col1_reg),
        .wr_newer     (cur1_reg),
        .wr_older     (above),
        .above        (above),
        .right        (right),
        .older        (older)
    );

    dgpe_grad u_grad (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (v1_reg),
        .in_ready   (g_in_ready),
        .in_meta    (meta1_reg),
        .cur        (cur1_reg),
        .right      (right),
        .left_above (left_above_reg),
        .older      (older),
        .out_valid  (g_out_valid),
        .out_ready  (o_in_ready),
        .out_meta   (g_meta),
        .out_energy (g_energy)
    );

    dgpe_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (g_out_valid),
        .in_ready    (o_in_ready),
        .in_meta     (g_meta),
        .in_energy   (g_energy),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .energy      (energy),
        .row_index   (row_index),
        .col_index   (col_index),
        .last_in_run (m_tlast)
    );

    assign m_tdata = {7'b0, col_index, row_index, energy};

endmodule

`default_nettype wire

/* design/dgpe_line_buf.sv */
// Two line buffers (row r-1 and row r-2) in synchronous RAM with registered reads.
// The newer row has two read ports (column c and c+1), the older row one.
// Depends on dgpe_pkg.
`default_nettype none

module dgpe_line_buf
    import dgpe_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    input  wire logic [AW-1:0] rd_addr_next,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire pixel_t        wr_newer,
    input  wire pixel_t        wr_older,
    output pixel_t             above,
    output pixel_t             right,
    output pixel_t             older
);

    pixel_t newer_mem [DEPTH];
    pixel_t older_mem [DEPTH];

    pixel_t above_reg;
    pixel_t right_reg;
    pixel_t older_reg;

    // Registered reads, old data on a same-edge write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            above_reg <= newer_mem[rd_addr];
            right_reg <= newer_mem[rd_addr_next];
            older_reg <= older_mem[rd_addr];
        end
    end

    // Write-back of one column in both rows
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            newer_mem[wr_addr] <= wr_newer;
            older_mem[wr_addr] <= wr_older;
        end
    end

    assign above = above_reg;
    assign right = right_reg;
    assign older = older_reg;

endmodule

`default_nettype wire

/* design/dgpe_grad.sv */
// Gradient datapath: squared channel differences, then their sum and border select.
// Two register stages with per-stage valid and bubble collapse. Depends on dgpe_pkg.
`default_nettype none

module dgpe_grad
    import dgpe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire item_meta_t in_meta,
    input  wire pixel_t     cur,
    input  wire pixel_t     right,
    input  wire pixel_t     left_above,
    input  wire pixel_t     older,
    output logic            out_valid,
    input  wire logic       out_ready,
    output item_meta_t      out_meta,
    output logic [18:0]     out_energy
);

    logic        va_reg;
    logic        vb_reg;
    logic        ena;
    logic        enb;
    logic [15:0] sq_reg [6];
    logic [15:0] sq_next [6];
    item_meta_t  meta_a_reg;
    item_meta_t  meta_b_reg;
    logic [18:0] energy_reg;
    logic [18:0] energy_next;

    assign enb      = !vb_reg || out_ready;
    assign ena      = !va_reg || enb;
    assign in_ready = ena;

    // Horizontal pair (right, left) and vertical pair (below, above)
    always_comb
    begin
        sq_next[0] = sq_diff(right.red,   left_above.red);
        sq_next[1] = sq_diff(right.green, left_above.green);
        sq_next[2] = sq_diff(right.blue,  left_above.blue);
        sq_next[3] = sq_diff(cur.red,     older.red);
        sq_next[4] = sq_diff(cur.green,   older.green);
        sq_next[5] = sq_diff(cur.blue,    older.blue);
    end

    // Sum of six squares, border pixels forced to the constant
    always_comb
    begin
        if (meta_a_reg.border)
            energy_next = BORDER_ENERGY;
        else
            energy_next = 19'(sq_reg[0]) + 19'(sq_reg[1]) + 19'(sq_reg[2])
                        + 19'(sq_reg[3]) + 19'(sq_reg[4]) + 19'(sq_reg[5]);
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (ena)
                va_reg <= in_valid;
            if (enb)
                vb_reg <= va_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (ena && in_valid)
        begin
            sq_reg     <= sq_next;
            meta_a_reg <= in_meta;
        end
        if (enb && va_reg)
        begin
            energy_reg <= energy_next;
            meta_b_reg <= meta_a_reg;
        end
    end

    assign out_valid  = vb_reg;
    assign out_meta   = meta_b_reg;
    assign out_energy = energy_reg;

endmodule

`default_nettype wire

/* design/dgpe_out.sv */
// Output register: turns one pixel into zero, one or two results (energy of the
// pixel above, then the border result of a last-row pixel). Depends on dgpe_pkg.
`default_nettype none

module dgpe_out
    import dgpe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire item_meta_t in_meta,
    input  wire logic [18:0] in_energy,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [18:0]     energy,
    output logic [11:0]     row_index,
    output logic [9:0]      col_index,
    output logic            last_in_run
);

    logic        ov_reg;
    logic        ov_next;
    logic        pend_reg;
    logic        pend_next;
    logic [18:0] energy_reg;
    logic [18:0] energy_next;
    logic [11:0] row_reg;
    logic [11:0] row_next;
    logic [11:0] row2_reg;
    logic [9:0]  col_reg;
    logic        last_reg;
    logic        last_next;
    logic        load;

    // Take a new pixel once the last pending result leaves
    assign in_ready = !ov_reg || (out_ready && !pend_reg);
    assign load     = in_valid && in_ready;

    always_comb
    begin
        ov_next     = ov_reg;
        pend_next   = pend_reg;
        energy_next = energy_reg;
        row_next    = row_reg;
        last_next   = last_reg;
        if (load)
        begin
            if (in_meta.has_above)
            begin
                ov_next     = 1'b1;
                pend_next   = in_meta.last_row;
                energy_next = in_energy;
                row_next    = in_meta.row_above;
                last_next   = !in_meta.last_row;
            end
            else
            begin
                // Only a last-row border result, or nothing on an inner first row
                ov_next     = in_meta.last_row;
                pend_next   = 1'b0;
                energy_next = BORDER_ENERGY;
                row_next    = in_meta.row_cur;
                last_next   = 1'b1;
            end
        end
        else if (ov_reg && out_ready)
        begin
            if (pend_reg)
            begin
                pend_next   = 1'b0;
                energy_next = BORDER_ENERGY;
                row_next    = row2_reg;
                last_next   = 1'b1;
            end
            else
            begin
                ov_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg   <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            ov_reg   <= ov_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        energy_reg <= energy_next;
        row_reg    <= row_next;
        last_reg   <= last_next;
        if (load)
        begin
            row2_reg <= in_meta.row_cur;
            col_reg  <= in_meta.col;
        end
    end

    assign out_valid   = ov_reg;
    assign energy      = energy_reg;
    assign row_index   = row_reg;
    assign col_index   = col_reg;
    assign last_in_run = last_reg;

endmodule

`default_nettype wire

/* dv/dual_gradient_pixel_energy_test.sv */
// Self-checking testbench for dual_gradient_pixel_energy: random RGB frames under several
// image sizes, with energies predicted in-bench and compared result by result.
// Depends on dgpe_pkg and the dual_gradient_pixel_energy RTL.
`default_nettype none

module dual_gradient_pixel_energy_test;
    import dgpe_pkg::*;

    localparam int LINE_MAX   = 1024;
    localparam int ROWS_MAX   = 4096;
    localparam int DRAIN_CYC  = 8;
    localparam int PIXEL_GOAL = 950;

    // One expected energy result
    typedef struct {
        logic [18:0] energy;
        logic [11:0] row;
        logic [9:0]  col;
        logic        last;
    } energy_rec_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata  = '0;     // red[7:0], green[15:8], blue[23:16]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [47:0]           m_tdata;           // energy[18:0], row_index[30:19],
                                              // col_index[40:31], zeros[47:41]
    logic                  m_tlast;           // last_in_run
    logic                  wr_en    = 1'b0;
    logic                  wr_index = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] wr_data  = '0;

    // Stimulus and expectation stores
    pixel_t      pixel_q[$];
    energy_rec_t energy_due_q[$];
    int          pix_offer_n = 0;
    int          pix_taken_n = 0;
    int          pixels_sent = 0;
    int          pix_gap     = 0;
    int          pix_calm    = 0;
    int          out_gap     = 0;
    int          out_calm    = 0;
    int          err_count   = 0;
    int          result_n    = 0;

    // Energy predictor state
    pixel_t      row_prev2 [LINE_MAX];
    pixel_t      row_prev1 [LINE_MAX];
    pixel_t      left_up;
    int unsigned cur_row;
    int unsigned cur_col;
    logic [10:0] width_reg;
    logic [12:0] height_reg;

    dual_gradient_pixel_energy dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #5 clk = ~clk;

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= 40)
            $display("ERROR: %s", msg);
    endtask

    // Random idle gap per request, with occasional back-to-back stretches
    function automatic int draw_gap(inout int calm);
        int gap;
        if (calm > 0)
        begin
            calm--;
            gap = 0;
        end
        else if ($urandom_range(0, 19) == 0)
        begin
            calm = $urandom_range(8, 40);
            gap  = 0;
        end
        else
            gap = $urandom_range(0, 9);
        return gap;
    endfunction

    function automatic int unsigned frame_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > LINE_MAX)
            return LINE_MAX;
        return width_reg;
    endfunction

    function automatic int unsigned frame_height();
        if (height_reg == 0)
            return 1;
        if (height_reg > ROWS_MAX)
            return ROWS_MAX;
        return height_reg;
    endfunction

    // Sum over channels of the squared difference
    function automatic int unsigned grad_sq(input pixel_t a, input pixel_t b);
        int dr, dg, db;
        dr = int'(a.red) - int'(b.red);
        dg = int'(a.green) - int'(b.green);
        db = int'(a.blue) - int'(b.blue);
        return dr * dr + dg * dg + db * db;
    endfunction

    // Expected results for one accepted pixel; advances the raster position
    task automatic predict_energy(input pixel_t px);
        int unsigned w, h, r, c;
        pixel_t      above;
        bit          last_row;
        energy_rec_t rec;
        w        = frame_width();
        h        = frame_height();
        r        = cur_row;
        c        = cur_col;
        above    = row_prev1[c];
        last_row = (r == h - 1);
        // pixel above is now complete
        if (r >= 1)
        begin
            if (r == 1 || c == 0 || c == w - 1)
                rec.energy = BORDER_ENERGY;
            else
                rec.energy = 19'(grad_sq(row_prev1[c + 1], left_up) + grad_sq(px, row_prev2[c]));
            rec.row  = 12'(r - 1);
            rec.col  = 10'(c);
            rec.last = !last_row;
            energy_due_q.push_back(rec);
        end
        // bottom row gives its own border value too
        if (last_row)
        begin
            rec.energy = BORDER_ENERGY;
            rec.row    = 12'(r);
            rec.col    = 10'(c);
            rec.last   = 1'b1;
            energy_due_q.push_back(rec);
        end
        left_up      = above;
        row_prev2[c] = above;
        row_prev1[c] = px;
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        cur_col = c;
        cur_row = r;
    endtask

    function automatic bit stream_idle();
        return pixel_q.size() == 0 && pix_taken_n == pix_offer_n && energy_due_q.size() == 0;
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (!stream_idle());
        repeat (DRAIN_CYC) @(negedge clk);
    endtask

    // Register write; restarts the frame in the predictor as well
    task automatic write_reg(input logic idx, input int value);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value[CFG_DATA_W-1:0];
        if (idx == REG_IMAGE_WIDTH)
            width_reg = value[10:0];
        else
            height_reg = value[12:0];
        cur_row = 0;
        cur_col = 0;
        @(negedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic push_px(input int r, input int g, input int b);
        pixel_t px;
        px.red   = r[7:0];
        px.green = g[7:0];
        px.blue  = b[7:0];
        pixel_q.push_back(px);
        pixels_sent++;
    endtask

    function automatic int rand_chan();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic push_random(input int n);
        repeat (n) push_px(rand_chan(), rand_chan(), rand_chan());
    endtask

    // Pixel driver: changes on the falling edge, holds a request until taken
    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && pix_taken_n != pix_offer_n))
        begin
            if (pix_gap > 0)
            begin
                s_tvalid <= 1'b0;
                pix_gap--;
            end
            else if (pixel_q.size() > 0)
            begin
                pixel_t px;
                px = pixel_q[0];
                pixel_q.delete(0);
                s_tdata  <= {px.blue, px.green, px.red};
                s_tvalid <= 1'b1;
                pix_offer_n++;
                pix_gap = draw_gap(pix_calm);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Pixel acceptance feeds the predictor
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            pixel_t px;
            px.red   = s_tdata[7:0];
            px.green = s_tdata[15:8];
            px.blue  = s_tdata[23:16];
            predict_energy(px);
            pix_taken_n++;
        end
    end

    // Result side back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_gap > 0)
            begin
                m_tready <= 1'b0;
                out_gap--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            energy_rec_t want;
            out_gap = draw_gap(out_calm);
            result_n++;
            if (energy_due_q.size() == 0)
                flag_error($sformatf("result %0d with none expected: energy %0d row %0d col %0d",
                                     result_n, m_tdata[18:0], m_tdata[30:19], m_tdata[40:31]));
            else
            begin
                want = energy_due_q[0];
                energy_due_q.delete(0);
                if (m_tdata[18:0] !== want.energy)
                    flag_error($sformatf("result %0d energy: got %0d want %0d",
                                         result_n, m_tdata[18:0], want.energy));
                if (m_tdata[30:19] !== want.row)
                    flag_error($sformatf("result %0d row_index: got %0d want %0d",
                                         result_n, m_tdata[30:19], want.row));
                if (m_tdata[40:31] !== want.col)
                    flag_error($sformatf("result %0d col_index: got %0d want %0d",
                                         result_n, m_tdata[40:31], want.col));
                if (m_tlast !== want.last)
                    flag_error($sformatf("result %0d last_in_run: got %0b want %0b",
                                         result_n, m_tlast, want.last));
            end
        end
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("** dual_gradient_pixel_energy: FAILED **");
        $finish;
    end

    // Stimulus sequence
    initial
    begin
        int w, h, pick, order, n, area;
        for (int i = 0; i < LINE_MAX; i++)
        begin
            row_prev2[i] = '0;
            row_prev1[i] = '0;
        end
        left_up    = '0;
        cur_row    = 0;
        cur_col    = 0;
        width_reg  = 11'(CFG_WIDTH_RESET);
        height_reg = 13'(CFG_HEIGHT_RESET);
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset geometry: first row stays silent
        push_random(3);
        wait_drained();

        // 3x3 frame; the center pixel is the only one not on the border
        write_reg(REG_IMAGE_WIDTH, 3);
        write_reg(REG_IMAGE_HEIGHT, 3);
        push_px(255, 0, 255);
        push_px(0, 0, 0);
        push_px(255, 255, 255);
        push_px(0, 0, 0);
        push_px(8'h55, 8'hAA, 8'h0F);
        push_px(255, 255, 255);
        push_px(0, 255, 0);
        push_px(255, 255, 255);
        push_px(0, 0, 0);
        wait_drained();

        // zero width acts as one column; two frames of height two
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 2);
        push_random(4);
        wait_drained();

        // oversized width saturates; a single row is also the last row
        write_reg(REG_IMAGE_WIDTH, 2047);
        write_reg(REG_IMAGE_HEIGHT, 1);
        push_random(3);
        wait_drained();

        // largest geometry: the first row only, no results
        write_reg(REG_IMAGE_HEIGHT, 8191);
        write_reg(REG_IMAGE_WIDTH, LINE_MAX);
        push_random(120);
        wait_drained();

        // random geometries, mostly small frames
        while (pixels_sent < PIXEL_GOAL)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 3)
            begin
                w = $urandom_range(0, 3);
                h = $urandom_range(0, 3);
            end
            else if (pick == 3)
            begin
                w = $urandom_range(17, 64);
                h = $urandom_range(2, 4);
            end
            else
            begin
                w = $urandom_range(1, 16);
                h = $urandom_range(1, 10);
            end
            // upper data bits are outside the width register
            w = w | ($urandom_range(0, 3) << 11);
            wait_drained();
            order = $urandom_range(0, 4);
            if (order <= 1 || order == 3)
                write_reg(REG_IMAGE_WIDTH, w);
            if (order != 3)
                write_reg(REG_IMAGE_HEIGHT, h);
            if (order == 2)
                write_reg(REG_IMAGE_WIDTH, w);
            area = frame_width() * frame_height();
            n    = $urandom_range(1, 2 * area + frame_width());
            if (n > 160)
                n = $urandom_range(100, 160);
            push_random(n);
        end

        do
            @(negedge clk);
        while (!stream_idle());
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("** dual_gradient_pixel_energy: PASSED **");
        else
            $display("** dual_gradient_pixel_energy: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
